// File: sv/nps_pkg.sv
// ----------------------------------------------------------------------------
// Nearest palette color search: shared definitions
// Sizes, the item kinds, the record that travels down the cell chain, and
// the per-channel squared difference.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int INDEX_W       = 8;   // entry_index and nearest_index
  localparam int CHAN_W        = 8;
  localparam int SIZE_W        = 9;   // palette_size register
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = SQ_W + 2;  // sum of three squares

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  // One item on its way through the chain, with the running best match.
  typedef struct packed {
    kind_e               kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [DIST_W-1:0]   best_dist;
    logic [INDEX_W-1:0]  best_index;
  } link_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// File: sv/nps_cell.sv
// ----------------------------------------------------------------------------
// Nearest palette color search: palette cell
// Holds one palette entry. Stage one stores a matching write or measures the
// squared distance to a lookup pixel; stage two keeps the better match.
// ----------------------------------------------------------------------------
module nps_cell import nps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [SIZE_W-1:0] active_size_i,
  input  logic              link_valid_i,
  input  link_t             link_i,
  output logic              link_valid_o,
  output link_t             link_o
);

  logic [CHAN_W-1:0] ent_red_q, ent_green_q, ent_blue_q;
  logic              a_valid_q, b_valid_q;
  link_t             a_q, b_q, b_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic              wr_hit;
  logic              in_range;

  assign wr_hit = adv_i && link_valid_i && (link_i.kind == KIND_WRITE) &&
                  (link_i.entry_index == INDEX_W'(cell_idx_i));

  assign dist_d = DIST_W'(sq_diff(ent_red_q,   link_i.red))
                + DIST_W'(sq_diff(ent_green_q, link_i.green))
                + DIST_W'(sq_diff(ent_blue_q,  link_i.blue));

  assign in_range = SIZE_W'(cell_idx_i) < active_size_i;

  // Strict less-than keeps the lower index on a tie.
  always_comb begin
    b_d = a_q;
    if (a_q.kind == KIND_LOOKUP && in_range && dist_q < a_q.best_dist) begin
      b_d.best_dist  = dist_q;
      b_d.best_index = INDEX_W'(cell_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= link_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q    <= link_i;
      dist_q <= dist_d;
      b_q    <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      ent_red_q   <= link_i.red;
      ent_green_q <= link_i.green;
      ent_blue_q  <= link_i.blue;
    end
  end

  assign link_valid_o = b_valid_q;
  assign link_o       = b_q;

endmodule

// File: sv/nearest_palette_color_search.sv
// Each palette cell adds two register stages, and the output register follows the chain.
// Throughput: one item per cycle while in_stall_o is low.
// A lookup result waiting at the output stalls the chain only when the next
// lookup reaches the end of the chain.
// Reset clears all valid bits and sets palette_size to 256; the palette
// itself is undefined until written.
// ----------------------------------------------------------------------------
// Nearest palette color search
// A chain of palette cells. Write items store an entry in the cell of that
// index; lookup items pass every cell and leave with the nearest index.
// ----------------------------------------------------------------------------
module nearest_palette_color_search import nps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [INDEX_W-1:0] entry_index_i,
  input  logic [CHAN_W-1:0]  red_i,
  input  logic [CHAN_W-1:0]  green_i,
  input  logic [CHAN_W-1:0]  blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [INDEX_W-1:0] nearest_index_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SIZE_W-1:0]  cfg_data_i
);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] r;
    r = n;
    if (n == '0) r = SIZE_W'(1);
    else if (n > SIZE_W'(PALETTE_DEPTH)) r = SIZE_W'(PALETTE_DEPTH);
    return r;
  endfunction

  logic [SIZE_W-1:0]  size_q;
  logic               link_valid [PALETTE_DEPTH+1];
  link_t              link       [PALETTE_DEPTH+1];
  logic               tail_lookup;
  logic               out_free;
  logic               adv;
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(PALETTE_DEPTH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= clamp_size(cfg_data_i);
    end
  end

  // The running best distance starts above any real distance, so cell zero
  // always takes over.
  assign link_valid[0]          = in_valid_i;
  assign link[0].kind           = kind_e'(kind_i);
  assign link[0].entry_index    = entry_index_i;
  assign link[0].red            = red_i;
  assign link[0].green          = green_i;
  assign link[0].blue           = blue_i;
  assign link[0].best_dist      = '1;
  assign link[0].best_index     = '0;

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    nps_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .cell_idx_i    (IDX_W'(k)),
      .active_size_i (size_q),
      .link_valid_i  (link_valid[k]),
      .link_i        (link[k]),
      .link_valid_o  (link_valid[k+1]),
      .link_o        (link[k+1])
    );
  end

  // Write items drop off the end of the chain; only lookups need the
  // output register.
  assign tail_lookup = link_valid[PALETTE_DEPTH] &&
                       (link[PALETTE_DEPTH].kind == KIND_LOOKUP);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = out_free || !tail_lookup;
  assign in_stall_o  = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tail_lookup && adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_lookup && adv) begin
      out_index_q <= link[PALETTE_DEPTH].best_index;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_index_q;

`ifndef ASSERT_OFF
  a_stall_only_on_blocked_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && tail_lookup)
  ) else $error("input stalled while the output path is free");

  a_lookup_reaches_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (tail_lookup && !in_stall_o) |=> out_valid_o
  ) else $error("lookup left the chain without a result");

  a_write_gives_no_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!tail_lookup && !out_valid_o) |=> !out_valid_o
  ) else $error("result appeared without a lookup at the end of the chain");
`endif

endmodule

// File: sim/nearest_palette_color_search_test.sv
// ----------------------------------------------------------------------------
// Nearest palette color search: self-checking testbench
// Drives palette writes and pixel lookups through the valid/stall ports and
// checks every lookup result against a predictor of the palette search.
// The palette size register is rewritten between phases, while the block is
// idle. One phase holds off the output long enough to fill the chain.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_test;
  import nps_pkg::*;

  localparam int LATENCY      = 2 * PALETTE_DEPTH + 1;
  localparam int SETTLE_CYCLE = LATENCY + 64;
  localparam int HOLD_CYCLES  = 2500;

  // Keeps its own palette and size register and the queue of nearest
  // indexes that the pending lookups must produce, oldest first.
  class nearest_index_board;
    logic [CHAN_W-1:0]  pal_red   [PALETTE_DEPTH];
    logic [CHAN_W-1:0]  pal_green [PALETTE_DEPTH];
    logic [CHAN_W-1:0]  pal_blue  [PALETTE_DEPTH];
    logic [SIZE_W-1:0]  size_reg;
    logic [INDEX_W-1:0] pending_index [$];
    int unsigned        mismatches;
    int unsigned        writes;
    int unsigned        lookups;

    function new();
      size_reg   = SIZE_W'(PALETTE_DEPTH);
      mismatches = 0;
      writes     = 0;
      lookups    = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // Zero searches one entry; anything past the depth searches all of them.
    function int unsigned searched_entries();
      if (size_reg == 0) return 1;
      if (size_reg > PALETTE_DEPTH) return 32'(PALETTE_DEPTH);
      return 32'(size_reg);
    endfunction

    function logic [INDEX_W-1:0] nearest_entry(logic [CHAN_W-1:0] r,
                                               logic [CHAN_W-1:0] g,
                                               logic [CHAN_W-1:0] b);
      int unsigned best;
      longint      best_dist;
      longint      sq_dist;
      int          dr;
      int          dg;
      int          db;
      best      = 0;
      best_dist = 64'h7fff_ffff_ffff;
      for (int unsigned e = 0; e < searched_entries(); e++) begin
        dr      = int'(pal_red[e]) - int'(r);
        dg      = int'(pal_green[e]) - int'(g);
        db      = int'(pal_blue[e]) - int'(b);
        sq_dist = longint'(dr * dr + dg * dg + db * db);
        // Strictly less keeps the lowest index on a tie.
        if (sq_dist < best_dist) begin
          best_dist = sq_dist;
          best      = e;
        end
      end
      return INDEX_W'(best);
    endfunction

    function void note_item(kind_e k, logic [INDEX_W-1:0] idx, logic [CHAN_W-1:0] r,
                            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
      if (k == KIND_WRITE) begin
        pal_red[idx]   = r;
        pal_green[idx] = g;
        pal_blue[idx]  = b;
        writes++;
      end else begin
        pending_index = {pending_index, nearest_entry(r, g, b)};
        lookups++;
      end
    endfunction

    function void check_result(logic [INDEX_W-1:0] got);
      logic [INDEX_W-1:0] want;
      if (pending_index.size() == 0) begin
        $error("nearest_index: result %0d arrived with no lookup pending", got);
        mismatches++;
        return;
      end
      want = pending_index.pop_front();
      if (got !== want) begin
        $error("nearest_index: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic [INDEX_W-1:0] entry_index_i;
  logic [CHAN_W-1:0]  red_i;
  logic [CHAN_W-1:0]  green_i;
  logic [CHAN_W-1:0]  blue_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [INDEX_W-1:0] nearest_index_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [SIZE_W-1:0]  cfg_data_i;

  nearest_index_board board = new();
  bit                 calm;
  bit                 squeeze_req;
  bit                 squeeze_done;
  int unsigned        settings;

  nearest_palette_color_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .entry_index_i   (entry_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .nearest_index_o (nearest_index_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("nearest_palette_color_search_test failed");
    $finish;
  end

  // Results are taken at the rising edge; the stall seen there was set at
  // the falling edge before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(nearest_index_o);
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
        squeeze_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
      end else begin
        @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic offer_item(kind_e k, logic [INDEX_W-1:0] idx, logic [CHAN_W-1:0] r,
                            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      repeat (n) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    kind_i        = k;
    entry_index_i = idx;
    red_i         = r;
    green_i       = g;
    blue_i        = b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(k, idx, r, g, b);
  endtask

  // The register is only written once all lookups are back and any write
  // still in the chain has had time to reach its cell.
  task automatic set_palette_size(logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending_index.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_size(value);
    settings++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Corner values make exact ties between entries far more likely.
  function automatic logic [CHAN_W-1:0] pick_chan();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: return 8'd0;
        1: return 8'd1;
        2: return 8'd127;
        3: return 8'd128;
        4: return 8'd254;
        default: return 8'd255;
      endcase
    end
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // Every entry must already hold a color before this runs.
  task automatic random_phase(logic [SIZE_W-1:0] value, int count);
    int unsigned        reach;
    int unsigned        e;
    kind_e              k;
    logic [INDEX_W-1:0] idx;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    set_palette_size(value);
    reach = board.searched_entries();
    for (int i = 0; i < count; i++) begin
      k   = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_LOOKUP;
      idx = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, reach - 1))
                                 : INDEX_W'($urandom_range(0, 255));
      if (k == KIND_LOOKUP && $urandom_range(0, 4) == 0) begin
        // A pixel that hits a stored color exactly.
        e = $urandom_range(0, reach - 1);
        r = board.pal_red[e];
        g = board.pal_green[e];
        b = board.pal_blue[e];
      end else begin
        r = pick_chan();
        g = pick_chan();
        b = pick_chan();
      end
      offer_item(k, idx, r, g, b);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_WRITE;
    entry_index_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    squeeze_req   = 1'b0;
    squeeze_done  = 1'b0;
    settings      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Search only entry zero while the first five entries are written.
    set_palette_size(9'd1);
    offer_item(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_item(KIND_WRITE, 8'd1, 8'd255, 8'd255, 8'd255);
    offer_item(KIND_WRITE, 8'd2, 8'd255, 8'd0, 8'd0);
    offer_item(KIND_WRITE, 8'd3, 8'd255, 8'd0, 8'd0);
    offer_item(KIND_WRITE, 8'd4, 8'd2, 8'd0, 8'd0);
    offer_item(KIND_LOOKUP, 8'd255, 8'd0, 8'd0, 8'd0);
    offer_item(KIND_LOOKUP, 8'd0, 8'd255, 8'd255, 8'd255);

    // A size of zero still searches entry zero.
    set_palette_size(9'd0);
    offer_item(KIND_LOOKUP, 8'd0, 8'd200, 8'd10, 8'd10);
    offer_item(KIND_LOOKUP, 8'd170, 8'd255, 8'd255, 8'd255);

    // Duplicate entries and a pixel halfway between two entries both test
    // the lowest-index rule.
    set_palette_size(9'd5);
    offer_item(KIND_LOOKUP, 8'd85, 8'd255, 8'd255, 8'd255);
    offer_item(KIND_LOOKUP, 8'd0, 8'd255, 8'd0, 8'd0);
    offer_item(KIND_LOOKUP, 8'd0, 8'd128, 8'd128, 8'd128);
    offer_item(KIND_LOOKUP, 8'd0, 8'd127, 8'd127, 8'd127);
    offer_item(KIND_LOOKUP, 8'd0, 8'd1, 8'd0, 8'd0);
    offer_item(KIND_LOOKUP, 8'd0, 8'd0, 8'd255, 8'd0);
    offer_item(KIND_LOOKUP, 8'd0, 8'd254, 8'd1, 8'd1);
    offer_item(KIND_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd255);

    for (int i = 0; i < PALETTE_DEPTH; i++)
      offer_item(KIND_WRITE, INDEX_W'(i), pick_chan(), pick_chan(), pick_chan());

    // Drain first so that the long hold-off meets a sender that keeps going.
    set_palette_size(9'd256);
    squeeze_req = 1'b1;
    random_phase(9'd256, 600);
    random_phase(9'd511, 120);
    random_phase(SIZE_W'($urandom_range(2, 255)), 120);
    random_phase(9'd300, 80);
    random_phase(9'd1, 50);
    random_phase(SIZE_W'($urandom_range(2, 255)), 80);
    calm = 1'b1;
    random_phase(9'd256, 120);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending_index.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLE) @(posedge clk_i);

    $display("Checked %0d palette writes and %0d lookups under %0d size settings,",
             board.writes, board.lookups, settings);
    $display("including size zero, sizes past the depth and a long output hold-off.");
    if (board.mismatches == 0) begin
      $display("nearest_palette_color_search_test passed");
    end else begin
      $display("nearest_palette_color_search_test failed");
    end
    $finish;
  end

endmodule
